/* design/afr_pkg.sv */
// Shared types, constants and helpers of the ARQ fragment reassembler.
package afr_pkg;

  localparam int MAX_FRAGMENTS  = 64;
  localparam int FRAGMENT_BYTES = 31;
  localparam int FRAME_BITS     = FRAGMENT_BYTES * 8;
  localparam int SEQ_W          = 6;
  localparam int CNT_W          = 5;

  localparam int         ACK_BIT        = 7;
  localparam int         PHASE_BIT      = 6;
  localparam logic [7:0] ACK_FLAG       = 8'h80;
  localparam logic [3:0] VERSION_NIBBLE = 4'h4;

  localparam logic [1:0] KIND_ACK      = 2'd0;
  localparam logic [1:0] KIND_PEER_ACK = 2'd1;
  localparam logic [1:0] KIND_CHUNK    = 2'd2;

  localparam logic [2:0] OUT_HOLD      = 3'd0;
  localparam logic [2:0] OUT_PEER      = 3'd1;
  localparam logic [2:0] OUT_ACK_DONE  = 3'd2;
  localparam logic [2:0] OUT_ACK_CHECK = 3'd3;
  localparam logic [2:0] OUT_CHUNK     = 3'd4;

  typedef struct packed {
    logic [7:0]  header;
    logic [63:0] payload_a;
    logic [63:0] payload_b;
    logic [63:0] payload_c;
    logic [55:0] payload_d;
    logic        sender_phase;
  } frame_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  ack_header;
    logic [5:0]  acked_seq;
    logic [63:0] chunk_a;
    logic [63:0] chunk_b;
    logic [63:0] chunk_c;
    logic [55:0] chunk_d;
    logic [4:0]  chunk_bytes;
    logic [15:0] packet_length;
    logic        last;
  } result_t;

  typedef struct packed {
    logic       capture;
    logic       apply;
    logic       read_first;
    logic       check;
    logic       fetch;
    logic [2:0] out_sel;
  } cmd_t;

  typedef struct packed {
    logic hdr_ack;
    logic ack_ok;
    logic complete;
    logic more;
  } status_t;

  function automatic logic [FRAME_BITS-1:0] chunk_keep(input logic [CNT_W-1:0] count);
    logic [FRAME_BITS-1:0] keep;
    keep = '0;
    for (int k = 0; k < FRAGMENT_BYTES; k++) begin
      if (CNT_W'(k) < count) begin
        keep[FRAME_BITS-1-8*k -: 8] = 8'hFF;
      end
    end
    return keep;
  endfunction

endpackage

/* design/afr_stream_if.sv */
// Valid/ready stream channel carrying one payload item.
interface afr_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

/* design/afr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module afr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AddrW-1:0] rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* design/afr_datapath.sv */
// Reassembler datapath: frame register, tracking state, slot store and result register.
module afr_datapath #(
  parameter int MAX_FRAGMENTS = afr_pkg::MAX_FRAGMENTS
) (
  input  logic             clk,
  input  logic             rst,
  input  afr_pkg::frame_t  frame,
  input  afr_pkg::cmd_t    cmd,
  output afr_pkg::status_t status,
  output afr_pkg::result_t result
);

  localparam int IdxW = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
  localparam int Cap  = (MAX_FRAGMENTS - 1) * afr_pkg::FRAGMENT_BYTES;
  localparam int RemW = $clog2(Cap + 1);
  localparam int FB   = afr_pkg::FRAME_BITS;
  localparam logic [afr_pkg::SEQ_W:0] SeqLimit = (afr_pkg::SEQ_W + 1)'(MAX_FRAGMENTS);

  logic [7:0]               hdr;
  logic [FB-1:0]            body;
  logic                     sender_phase;
  logic                     receive_phase;
  logic                     start_seen;
  logic [7:0]               expected_count;
  logic [7:0]               received_count;
  logic [15:0]              pkt_len;
  logic [MAX_FRAGMENTS-1:0] fresh_mask;
  logic [RemW-1:0]          remaining;
  logic [IdxW-1:0]          chunk_slot;
  logic [15:0]              out_len;
  afr_pkg::result_t         res;

  logic [afr_pkg::SEQ_W-1:0] seq;
  logic [IdxW-1:0]           seq_idx;
  logic                      use_frame;
  logic                      start_new;
  logic                      frag_new;
  logic [7:0]                start_count;
  logic [15:0]               start_len;
  logic [FB-1:0]             ram_rdata;
  logic                      emit_ok;
  logic [RemW-1:0]           emit_len;
  logic [afr_pkg::CNT_W-1:0] cnt;

  assign seq         = hdr[afr_pkg::SEQ_W-1:0];
  assign seq_idx     = seq[IdxW-1:0];
  assign use_frame   = hdr[afr_pkg::PHASE_BIT] == receive_phase;
  assign start_count = body[FB-1 -: 8];
  assign start_len   = body[FB-9 -: 16];
  assign start_new   = use_frame && (seq == '0) && !start_seen;
  assign frag_new    = use_frame && (seq != '0) && ({1'b0, seq} < SeqLimit)
                       && fresh_mask[seq_idx];

  assign emit_ok  = (pkt_len != '0) && (ram_rdata[FB-1 -: 4] == afr_pkg::VERSION_NIBBLE);
  assign emit_len = (pkt_len < 16'(Cap)) ? pkt_len[RemW-1:0] : RemW'(Cap);
  assign cnt      = (remaining > RemW'(afr_pkg::FRAGMENT_BYTES))
                    ? afr_pkg::CNT_W'(afr_pkg::FRAGMENT_BYTES)
                    : remaining[afr_pkg::CNT_W-1:0];

  assign status.hdr_ack  = hdr[afr_pkg::ACK_BIT];
  assign status.ack_ok   = hdr[afr_pkg::PHASE_BIT] == sender_phase;
  assign status.complete = start_new ? (received_count == start_count)
                         : (frag_new && start_seen
                            && (8'(received_count + 8'd1) == expected_count));
  assign status.more     = remaining != '0;
  assign result          = res;

  afr_ram #(
    .WIDTH (FB),
    .DEPTH (MAX_FRAGMENTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.apply && frag_new),
    .wr_addr (seq_idx),
    .wr_data (body),
    .rd_en   (cmd.read_first || cmd.fetch),
    .rd_addr (cmd.read_first ? IdxW'(1) : chunk_slot),
    .rd_data (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      hdr          <= frame.header;
      body         <= {frame.payload_a, frame.payload_b, frame.payload_c, frame.payload_d};
      sender_phase <= frame.sender_phase;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receive_phase  <= 1'b1;
      start_seen     <= 1'b0;
      expected_count <= '0;
      received_count <= '0;
      pkt_len        <= '0;
      fresh_mask     <= '1;
      remaining      <= '0;
      chunk_slot     <= '0;
      out_len        <= '0;
    end else begin
      if (cmd.apply && start_new) begin
        start_seen     <= 1'b1;
        expected_count <= start_count;
        pkt_len        <= start_len;
      end
      if (cmd.apply && frag_new) begin
        fresh_mask[seq_idx] <= 1'b0;
        received_count      <= 8'(received_count + 8'd1);
      end
      if (cmd.check) begin
        receive_phase  <= ~receive_phase;
        start_seen     <= 1'b0;
        expected_count <= '0;
        received_count <= '0;
        pkt_len        <= '0;
        fresh_mask     <= '1;
        remaining      <= emit_ok ? emit_len : '0;
        chunk_slot     <= IdxW'(1);
        out_len        <= pkt_len;
      end
      if (cmd.out_sel == afr_pkg::OUT_CHUNK) begin
        remaining  <= remaining - RemW'(cnt);
        chunk_slot <= chunk_slot + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.out_sel)
      afr_pkg::OUT_HOLD: begin
      end
      afr_pkg::OUT_PEER: begin
        res           <= '0;
        res.kind      <= afr_pkg::KIND_PEER_ACK;
        res.acked_seq <= seq;
        res.last      <= 1'b1;
      end
      afr_pkg::OUT_ACK_DONE: begin
        res            <= '0;
        res.kind       <= afr_pkg::KIND_ACK;
        res.ack_header <= hdr | afr_pkg::ACK_FLAG;
        res.last       <= 1'b1;
      end
      afr_pkg::OUT_ACK_CHECK: begin
        res            <= '0;
        res.kind       <= afr_pkg::KIND_ACK;
        res.ack_header <= hdr | afr_pkg::ACK_FLAG;
        res.last       <= !emit_ok;
      end
      afr_pkg::OUT_CHUNK: begin
        res           <= '0;
        res.kind      <= afr_pkg::KIND_CHUNK;
        {res.chunk_a, res.chunk_b, res.chunk_c, res.chunk_d}
                      <= ram_rdata & afr_pkg::chunk_keep(cnt);
        res.chunk_bytes   <= cnt;
        res.packet_length <= out_len;
        res.last          <= remaining <= RemW'(afr_pkg::FRAGMENT_BYTES);
      end
      default: begin
      end
    endcase
  end

endmodule

/* design/afr_ctrl.sv */
// Reassembler controller: sequences decode, completion check and chunk drain.
module afr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  afr_pkg::status_t status,
  output afr_pkg::cmd_t    cmd
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_READ1  = 3'd2;
  localparam logic [2:0] S_CHECK  = 3'd3;
  localparam logic [2:0] S_WAIT   = 3'd4;
  localparam logic [2:0] S_FETCH  = 3'd5;
  localparam logic [2:0] S_LOAD   = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_ready  = state == S_IDLE;
  assign out_valid = state == S_WAIT;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (status.hdr_ack) begin
          if (status.ack_ok) begin
            cmd.out_sel = afr_pkg::OUT_PEER;
            state_next  = S_WAIT;
          end else begin
            state_next = S_IDLE;
          end
        end else begin
          cmd.apply = 1'b1;
          if (status.complete) begin
            state_next = S_READ1;
          end else begin
            cmd.out_sel = afr_pkg::OUT_ACK_DONE;
            state_next  = S_WAIT;
          end
        end
      end
      S_READ1: begin
        cmd.read_first = 1'b1;
        state_next     = S_CHECK;
      end
      S_CHECK: begin
        cmd.check   = 1'b1;
        cmd.out_sel = afr_pkg::OUT_ACK_CHECK;
        state_next  = S_WAIT;
      end
      S_WAIT: begin
        if (out_ready) begin
          state_next = status.more ? S_FETCH : S_IDLE;
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_LOAD;
      end
      S_LOAD: begin
        cmd.out_sel = afr_pkg::OUT_CHUNK;
        state_next  = S_WAIT;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

/* design/arq_fragment_reassembler_unit.sv */
// Top level of the ARQ fragment reassembler: controller, datapath and channels.
//
//   channel   dir  payload            item
//   frames    in   afr_pkg::frame_t   one 32-byte radio frame with sender phase
//   results   out  afr_pkg::result_t  ack, partner ack or packet chunk
//
// A frame with no completion passes through capture, decode and result hand-over
// before the next ready; an unmatched partner ack gives no result and goes from
// decode back to idle. Completion adds the slot 1 read and version check, then
// a fetch, load and hand-over per 31-byte chunk, set by the store's registered
// read port. One frame is in work at a time.
// Reset is synchronous; tracking is cleared on reset and the slot store is
// never cleared. A stalled result holds the block until it is taken.
module arq_fragment_reassembler_unit #(
  parameter int MAX_FRAGMENTS = afr_pkg::MAX_FRAGMENTS
) (
  input logic          clk,
  input logic          rst,
  afr_stream_if.sink   frames,
  afr_stream_if.source results
);

  afr_pkg::cmd_t    cmd;
  afr_pkg::status_t status;
  afr_pkg::result_t result;

  afr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (frames.valid),
    .in_ready  (frames.ready),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .status    (status),
    .cmd       (cmd)
  );

  afr_datapath #(
    .MAX_FRAGMENTS (MAX_FRAGMENTS)
  ) u_datapath (
    .clk    (clk),
    .rst    (rst),
    .frame  (frames.payload),
    .cmd    (cmd),
    .status (status),
    .result (result)
  );

  assign results.payload = result;

endmodule

/* verif/afr_result_checker.sv */
// Result checker of the ARQ fragment reassembler: predicts each result item and compares it.
module afr_result_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             frame_valid,
  input  logic             frame_ready,
  input  afr_pkg::frame_t  frame,
  input  logic             result_valid,
  input  logic             result_ready,
  input  afr_pkg::result_t result,
  output int               mismatches,
  output int               outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STORE_BYTES = 2048;
  localparam int EMIT_CAP    = (afr_pkg::MAX_FRAGMENTS - 1) * afr_pkg::FRAGMENT_BYTES;

  logic             rx_phase;
  logic             start_seen;
  logic [7:0]       want_count;
  logic [7:0]       got_count;
  logic [15:0]      announced_len;
  logic [63:0]      fresh_slots;
  logic [7:0]       packet_bytes [STORE_BYTES];
  afr_pkg::result_t step_results [$];
  afr_pkg::result_t due_results [$];

  task automatic clear_tracking();
    start_seen    = 1'b0;
    want_count    = '0;
    got_count     = '0;
    announced_len = '0;
    fresh_slots   = '1;
    foreach (packet_bytes[i]) packet_bytes[i] = '0;
  endtask

  task automatic finish_packet();
    int               emit;
    int               cnt;
    logic [247:0]     chunk;
    afr_pkg::result_t r;
    emit = (announced_len < EMIT_CAP) ? announced_len : EMIT_CAP;
    rx_phase = ~rx_phase;
    if (announced_len != 0 && packet_bytes[0][7:4] == afr_pkg::VERSION_NIBBLE) begin
      for (int off = 0; off < emit; off += afr_pkg::FRAGMENT_BYTES) begin
        cnt = (emit - off > afr_pkg::FRAGMENT_BYTES) ? afr_pkg::FRAGMENT_BYTES : emit - off;
        chunk = '0;
        for (int k = 0; k < cnt; k++) begin
          chunk[247 - 8 * k -: 8] = packet_bytes[off + k];
        end
        r = '0;
        r.kind = afr_pkg::KIND_CHUNK;
        {r.chunk_a, r.chunk_b, r.chunk_c, r.chunk_d} = chunk;
        r.chunk_bytes   = afr_pkg::CNT_W'(cnt);
        r.packet_length = announced_len;
        step_results.push_back(r);
      end
    end
    clear_tracking();
  endtask

  task automatic reassemble_frame(input afr_pkg::frame_t f);
    logic [247:0]     body;
    logic [5:0]       seq;
    int               base;
    afr_pkg::result_t r;
    body = {f.payload_a, f.payload_b, f.payload_c, f.payload_d};
    seq  = f.header[afr_pkg::SEQ_W-1:0];
    r    = '0;
    step_results.delete();
    if (f.header[afr_pkg::ACK_BIT]) begin
      if (f.header[afr_pkg::PHASE_BIT] == f.sender_phase) begin
        r.kind      = afr_pkg::KIND_PEER_ACK;
        r.acked_seq = seq;
        step_results.push_back(r);
      end
    end else begin
      r.kind       = afr_pkg::KIND_ACK;
      r.ack_header = f.header | afr_pkg::ACK_FLAG;
      step_results.push_back(r);
      if (f.header[afr_pkg::PHASE_BIT] == rx_phase) begin
        if (seq == 0) begin
          if (!start_seen) begin
            start_seen    = 1'b1;
            want_count    = body[247:240];
            announced_len = body[239:224];
            if (got_count == want_count) finish_packet();
          end
        end else if (seq < afr_pkg::MAX_FRAGMENTS && fresh_slots[seq]) begin
          fresh_slots[seq] = 1'b0;
          base = (int'(seq) - 1) * afr_pkg::FRAGMENT_BYTES;
          for (int k = 0; k < afr_pkg::FRAGMENT_BYTES; k++) begin
            packet_bytes[base + k] = body[247 - 8 * k -: 8];
          end
          got_count++;
          if (start_seen && got_count == want_count) finish_packet();
        end
      end
    end
    if (step_results.size() != 0) begin
      r = step_results[step_results.size() - 1];
      r.last = 1'b1;
      step_results[step_results.size() - 1] = r;
    end
    foreach (step_results[i]) due_results.push_back(step_results[i]);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    afr_pkg::result_t want;
    if (rst) begin
      rx_phase = 1'b1;
      clear_tracking();
      due_results.delete();
    end else begin
      if (result_valid && result_ready) begin
        if (due_results.size() == 0) begin
          $display("%0t ns: result item expected none actual kind %0d", $time, result.kind);
          mismatches++;
        end else begin
          want = due_results.pop_front();
          check_field("kind", want.kind, result.kind);
          check_field("ack_header", want.ack_header, result.ack_header);
          check_field("acked_seq", want.acked_seq, result.acked_seq);
          check_field("chunk_a", want.chunk_a, result.chunk_a);
          check_field("chunk_b", want.chunk_b, result.chunk_b);
          check_field("chunk_c", want.chunk_c, result.chunk_c);
          check_field("chunk_d", want.chunk_d, result.chunk_d);
          check_field("chunk_bytes", want.chunk_bytes, result.chunk_bytes);
          check_field("packet_length", want.packet_length, result.packet_length);
          check_field("last", want.last, result.last);
        end
      end
      if (frame_valid && frame_ready) reassemble_frame(frame);
    end
    outstanding = due_results.size();
  end

endmodule

/* verif/arq_fragment_reassembler_unit_test.sv */
// Testbench top of the ARQ fragment reassembler: clock, reset, frame stimulus and verdict.
module arq_fragment_reassembler_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 70;
  localparam int LONG_HOLD    = 400;
  localparam int DRAIN_CYCLES = 20;
  localparam int LIMIT_NS     = 30_000_000;
  localparam int EMIT_CAP     = (afr_pkg::MAX_FRAGMENTS - 1) * afr_pkg::FRAGMENT_BYTES;

  typedef int seq_list_t[$];

  logic clk = 1'b0;
  logic rst = 1'b1;
  int   mismatches;
  int   outstanding;
  int   items_sent;
  bit   rx_phase = 1'b1;
  bit   random_part;
  bit   steady;

  afr_stream_if #(.payload_t(afr_pkg::frame_t))  frames_ch ();
  afr_stream_if #(.payload_t(afr_pkg::result_t)) results_ch ();

  arq_fragment_reassembler_unit dut (
    .clk     (clk),
    .rst     (rst),
    .frames  (frames_ch),
    .results (results_ch)
  );

  afr_result_checker reassembly_check (
    .clk          (clk),
    .rst          (rst),
    .frame_valid  (frames_ch.valid),
    .frame_ready  (frames_ch.ready),
    .frame        (frames_ch.payload),
    .result_valid (results_ch.valid),
    .result_ready (results_ch.ready),
    .result       (results_ch.payload),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [247:0] random_body();
    logic [255:0] b;
    for (int i = 0; i < 8; i++) b[32 * i +: 32] = $urandom;
    return b[247:0];
  endfunction

  function automatic logic [247:0] start_body(input logic [7:0] count, input logic [15:0] len);
    logic [247:0] b;
    b = random_body();
    b[247:224] = {count, len};
    return b;
  endfunction

  function automatic logic [247:0] lead_body(input logic [7:0] first_byte);
    logic [247:0] b;
    b = random_body();
    b[247:240] = first_byte;
    return b;
  endfunction

  function automatic seq_list_t shuffled(input seq_list_t q);
    int j;
    int t;
    for (int i = q.size() - 1; i > 0; i--) begin
      j    = $urandom_range(0, i);
      t    = q[i];
      q[i] = q[j];
      q[j] = t;
    end
    return q;
  endfunction

  task automatic send_frame(input logic [7:0] hdr, input logic [247:0] body,
                            input logic sphase);
    afr_pkg::frame_t f;
    int              gap;
    f.header = hdr;
    {f.payload_a, f.payload_b, f.payload_c, f.payload_d} = body;
    f.sender_phase = sphase;
    gap = steady ? 0 : idle_gap();
    if (gap > 0) begin
      frames_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    frames_ch.valid   <= 1'b1;
    frames_ch.payload <= f;
    @(posedge clk);
    while (!frames_ch.ready) @(posedge clk);
    if (!(hdr[afr_pkg::ACK_BIT] && hdr[afr_pkg::PHASE_BIT] != sphase)) items_sent++;
  endtask

  // Every fragment covering the emitted bytes is part of the set, so no
  // completion ever reads a slot left unwritten.
  task automatic deliver_packet(input int count, input int len, input bit good_version,
                                input bit start_last);
    seq_list_t    order;
    seq_list_t    spare;
    seq_list_t    sent;
    int           needed;
    int           pick;
    logic [3:0]   nibble;
    logic [247:0] body;
    needed = ((len < EMIT_CAP ? len : EMIT_CAP) + afr_pkg::FRAGMENT_BYTES - 1)
             / afr_pkg::FRAGMENT_BYTES;
    for (int s = needed + 1; s < afr_pkg::MAX_FRAGMENTS; s++) spare.push_back(s);
    spare = shuffled(spare);
    for (int s = 1; s <= needed; s++) order.push_back(s);
    while (order.size() < count) order.push_back(spare.pop_front());
    order = shuffled(order);
    if (start_last) order.push_back(0);
    else order.insert($urandom_range(0, order.size()), 0);
    foreach (order[i]) begin
      if (i > 0 && $urandom_range(0, 3) == 0) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          send_frame({1'b0, rx_phase, 6'(sent[$urandom_range(0, sent.size() - 1)])},
                     random_body(), 1'($urandom));
        end else if (pick < 70) begin
          send_frame({1'b0, ~rx_phase, 6'($urandom)}, random_body(), 1'($urandom));
        end else begin
          send_frame({1'b1, 1'($urandom), 6'($urandom)}, random_body(), 1'($urandom));
        end
      end
      if (order[i] == 0) begin
        body = start_body(8'(count), 16'(len));
      end else if (order[i] == 1 && len != 0) begin
        nibble = 4'($urandom_range(0, 14));
        if (good_version) nibble = afr_pkg::VERSION_NIBBLE;
        else if (nibble >= afr_pkg::VERSION_NIBBLE) nibble++;
        body = lead_body({nibble, 4'($urandom)});
      end else begin
        body = random_body();
      end
      send_frame({1'b0, rx_phase, 6'(order[i])}, body, 1'($urandom));
      sent.push_back(order[i]);
    end
    rx_phase = ~rx_phase;
  endtask

  initial begin : result_ready_drive
    int  stall_left;
    int  run_left;
    bit  long_hold_done;
    stall_left     = 0;
    run_left       = 0;
    long_hold_done = 1'b0;
    results_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (random_part && !long_hold_done) begin
        long_hold_done = 1'b1;
        stall_left     = LONG_HOLD;
      end
      if (stall_left == 0 && run_left == 0) begin
        run_left   = $urandom_range(1, 24);
        stall_left = idle_gap();
      end
      if (stall_left > 0) begin
        results_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        results_ch.ready <= 1'b1;
        run_left--;
      end
    end
  end

  initial begin : frame_stimulus
    int count;
    int len;
    int long_slot;
    frames_ch.valid   <= 1'b0;
    frames_ch.payload <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // partner acks, matching and stale, then stale data
    send_frame(8'hFF, '1, 1'b1);
    send_frame(8'hC0, '0, 1'b0);
    send_frame(8'h80, random_body(), 1'b0);
    send_frame(8'h3F, '1, 1'b0);
    // duplicate fragment and repeated start inside a two-chunk packet
    send_frame(8'h40, start_body(8'd2, 16'd40), 1'b0);
    send_frame(8'h41, lead_body(8'h45), 1'b1);
    send_frame(8'h41, random_body(), 1'b0);
    send_frame(8'h40, start_body(8'd5, 16'd100), 1'b1);
    send_frame(8'h42, random_body(), 1'b0);
    // start arriving last, stale data in between
    send_frame(8'h01, lead_body(8'h4A), 1'b0);
    send_frame(8'h41, random_body(), 1'b1);
    send_frame(8'h00, start_body(8'd1, 16'd31), 1'b0);
    // bad version nibble
    send_frame(8'h40, start_body(8'd1, 16'd20), 1'b1);
    send_frame(8'h41, lead_body(8'h65), 1'b0);
    // zero length
    send_frame(8'h00, start_body(8'd1, 16'd0), 1'b1);
    send_frame(8'h05, random_body(), 1'b0);
    // highest sequence number and a lead fragment that is zero after its first byte
    send_frame(8'h7F, random_body(), 1'b1);
    send_frame(8'h40, start_body(8'd2, 16'd31), 1'b0);
    send_frame(8'h41, {8'h40, 240'd0}, 1'b1);
    // single-byte packet
    send_frame(8'h00, start_body(8'd1, 16'd1), 1'b0);
    send_frame(8'h01, {8'h4F, {240{1'b1}}}, 1'b1);

    random_part = 1'b1;
    items_sent  = 0;
    long_slot   = $urandom_range(0, 3);
    for (int p = 0; items_sent < RANDOM_ITEMS; p++) begin
      steady = ($urandom_range(0, 3) == 0);
      if (p == long_slot) begin
        len = ($urandom_range(0, 1) != 0) ? 65535 : $urandom_range(EMIT_CAP + 1, 65535);
        deliver_packet(afr_pkg::MAX_FRAGMENTS - 1, len, 1'b1, 1'($urandom));
      end else begin
        count = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
        if (count == 0 || $urandom_range(0, 6) == 0) len = 0;
        else len = $urandom_range(1, count * afr_pkg::FRAGMENT_BYTES);
        deliver_packet(count, len, $urandom_range(0, 7) != 0, $urandom_range(0, 3) == 0);
      end
    end

    // announced count beyond the slot range: the packet never completes
    steady = 1'b0;
    send_frame({1'b0, rx_phase, 6'd0}, start_body(8'($urandom_range(64, 255)), 16'($urandom)),
               1'($urandom));
    repeat (4) begin
      send_frame({1'b0, rx_phase, 6'($urandom_range(1, 63))}, random_body(), 1'($urandom));
    end
    frames_ch.valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin : run_limit
    #(LIMIT_NS);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
